// ===== sv/bpa_pkg.sv =====
// Shared types, constants and helpers for the bitmap page allocator.
// No dependencies; every other file imports this package.
package bpa_pkg;

	// Page space and bitmap geometry (NUM_PAGES is a multiple of WORD_W)
	localparam int NUM_PAGES = 4096;
	localparam int PAGE_W    = 12;
	localparam int COUNT_W   = $clog2(NUM_PAGES + 1);
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NUM_WORDS = NUM_PAGES / WORD_W;
	localparam int WADDR_W   = $clog2(NUM_WORDS);

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [WADDR_W-1:0] waddr_t;
	typedef logic [BIT_W-1:0]   bsel_t;
	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Operation codes; code 3 is unused and fails
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN
	} state_t;

	// Bitmap memory access, one read and one write port
	typedef struct packed {
		logic   rd_en;
		waddr_t rd_addr;
		logic   wr_en;
		waddr_t wr_addr;
		word_t  wr_data;
	} mem_req_t;

	// Lowest clear bit of a word: {found, index}
	function automatic logic [BIT_W:0] find_zero(input word_t w);
		logic  found;
		bsel_t idx;
		found = 1'b0;
		idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				found = 1'b1;
				idx   = BIT_W'(i);
			end
		end
		return {found, idx};
	endfunction

endpackage

// ===== sv/bitmap_page_allocator_top.sv =====
// First-fit page allocator over 4096 pages. A beat is taken when start is high and busy is
// low; each beat gives exactly one result, shown for one cycle with done high, and the
// receiver cannot stall it. Free and query read the bitmap word, modify it in ST_MOD and
// show their result from the done register; busy is high only in ST_MOD, so the next beat
// can be taken while the result is shown. Failures detected at acceptance (store full,
// index out of range, unused op) answer in the cycle right after acceptance without
// raising busy. An allocate also shows its page from ST_MOD through the done register, and,
// unless a free page remains in the same word, keeps busy high after ST_MOD while it scans
// the bitmap for the next free page at one 32-bit word per cycle. The bitmap memory needs
// no clearing pass after reset. Depends on bpa_pkg, bpa_bitmap_ram and bpa_ctrl.
module bitmap_page_allocator_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      op,
	input  bpa_pkg::page_t  page_index,
	output logic            done,
	output logic            ok,
	output bpa_pkg::page_t  granted_page,
	output logic            page_free
);
	import bpa_pkg::*;

	mem_req_t mem_req;
	word_t    rd_data;

	// Operation sequencer and hint scan
	bpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.page_index   (page_index),
		.busy         (busy),
		.done         (done),
		.ok           (ok),
		.granted_page (granted_page),
		.page_free    (page_free),
		.mem_req      (mem_req),
		.rd_data      (rd_data)
	);

	// Used-bit store
	bpa_bitmap_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

// ===== sv/bpa_bitmap_ram.sv =====
// Bitmap store: one word of used bits per row, synchronous read through a registered output.
// A row flag per word makes never-written rows read as all free. Depends on bpa_pkg.
module bpa_bitmap_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::mem_req_t  req,
	output bpa_pkg::word_t     rd_data
);
	import bpa_pkg::*;

	word_t                mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_valid_q;
	word_t                mem_rd_q;
	logic                 rd_valid_q;

	// Array write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q <= mem[req.rd_addr];
		end
	end

	// Row flags: cleared at reset, set on first write of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? mem_rd_q : '0;

endmodule

// ===== sv/bpa_ctrl.sv =====
// Allocator control: operation decode, read-modify-write of bitmap words,
// hint scan and result registers. Depends on bpa_pkg; drives bpa_bitmap_ram.
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  bpa_pkg::page_t     page_index,
	output logic               busy,
	output logic               done,
	output logic               ok,
	output bpa_pkg::page_t     granted_page,
	output logic               page_free,
	output bpa_pkg::mem_req_t  mem_req,
	input  bpa_pkg::word_t     rd_data
);
	import bpa_pkg::*;

	state_t   state_q, state_d;
	op_t      op_q, op_d;
	page_t    page_q, page_d;
	count_t   count_q, count_d;
	page_t    hint_q, hint_d;
	logic     hint_valid_q, hint_valid_d;
	waddr_t   scan_word_q, scan_word_d;
	logic     done_q, done_d;
	logic     ok_q, ok_d;
	page_t    granted_q, granted_d;
	logic     pfree_q, pfree_d;

	logic               in_range;
	bsel_t              bsel;
	waddr_t             cur_word;
	logic               cur_bit;
	word_t              bit_mask;
	word_t              word_set;
	word_t              word_clr;
	word_t              mask_le;
	word_t              fz_in;
	logic [BIT_W:0]     fz;
	waddr_t             fz_word;
	count_t             count_inc;

	assign busy = (state_q != ST_IDLE);

	// Datapath terms for the word just read
	always_comb begin
		in_range  = (COUNT_W'(page_index) < COUNT_W'(NUM_PAGES));
		bsel      = page_q[BIT_W-1:0];
		cur_word  = page_q[BIT_W +: WADDR_W];
		cur_bit   = rd_data[bsel];
		bit_mask  = word_t'(1) << bsel;
		word_set  = rd_data | bit_mask;
		word_clr  = rd_data & ~bit_mask;
		mask_le   = {WORD_W{1'b1}} >> (~bsel);
		fz_in     = (state_q == ST_SCAN) ? rd_data : (word_set | mask_le);
		fz        = find_zero(fz_in);
		fz_word   = (state_q == ST_SCAN) ? scan_word_q : cur_word;
		count_inc = count_q + COUNT_W'(1);
	end

	// Next state, memory requests and results
	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		page_d       = page_q;
		count_d      = count_q;
		hint_d       = hint_q;
		hint_valid_d = hint_valid_q;
		scan_word_d  = scan_word_q;
		done_d       = 1'b0;
		ok_d         = 1'b0;
		granted_d    = '0;
		pfree_d      = 1'b0;
		mem_req      = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d = op_t'(op);
					case (op)
						OP_ALLOC: begin
							if (count_q >= COUNT_W'(NUM_PAGES) || !hint_valid_q ||
							    COUNT_W'(hint_q) >= COUNT_W'(NUM_PAGES)) begin
								done_d = 1'b1;
							end else begin
								page_d          = hint_q;
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = hint_q[BIT_W +: WADDR_W];
								state_d         = ST_MOD;
							end
						end
						OP_FREE, OP_QUERY: begin
							if (!in_range) begin
								done_d = 1'b1;
							end else begin
								page_d          = page_index;
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = page_index[BIT_W +: WADDR_W];
								state_d         = ST_MOD;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			ST_MOD: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				case (op_q)
					OP_ALLOC: begin
						ok_d            = 1'b1;
						granted_d       = page_q;
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = cur_word;
						mem_req.wr_data = word_set;
						count_d         = count_inc;
						hint_valid_d    = 1'b0;
						if (count_inc < COUNT_W'(NUM_PAGES)) begin
							if (fz[BIT_W]) begin
								hint_d       = PAGE_W'({fz_word, fz[BIT_W-1:0]});
								hint_valid_d = 1'b1;
							end else if (cur_word != waddr_t'(NUM_WORDS - 1)) begin
								// continue in the following words
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = cur_word + waddr_t'(1);
								scan_word_d     = cur_word + waddr_t'(1);
								state_d         = ST_SCAN;
							end
						end
					end
					OP_FREE: begin
						if (cur_bit) begin
							ok_d            = 1'b1;
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = cur_word;
							mem_req.wr_data = word_clr;
							if (!hint_valid_q || page_q < hint_q) begin
								hint_d       = page_q;
								hint_valid_d = 1'b1;
							end
							if (count_q != '0) begin
								count_d = count_q - COUNT_W'(1);
							end
						end
					end
					default: begin
						// query
						ok_d    = 1'b1;
						pfree_d = !cur_bit;
					end
				endcase
			end

			ST_SCAN: begin
				if (fz[BIT_W]) begin
					hint_d       = PAGE_W'({fz_word, fz[BIT_W-1:0]});
					hint_valid_d = 1'b1;
					state_d      = ST_IDLE;
				end else if (scan_word_q == waddr_t'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = scan_word_q + waddr_t'(1);
					scan_word_d     = scan_word_q + waddr_t'(1);
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			hint_q       <= '0;
			hint_valid_q <= 1'b1;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			hint_q       <= hint_d;
			hint_valid_q <= hint_valid_d;
			done_q       <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		op_q        <= op_d;
		page_q      <= page_d;
		scan_word_q <= scan_word_d;
		ok_q        <= ok_d;
		granted_q   <= granted_d;
		pfree_q     <= pfree_d;
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign granted_page = granted_q;
	assign page_free    = pfree_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(NUM_PAGES))
		else $error("allocated count above page total");

	a_hint_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !hint_valid_q) |-> count_q == COUNT_W'(NUM_PAGES))
		else $error("hint invalid while pages remain free");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done_q || busy))
		else $error("accepted beat neither answered nor in progress");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (granted_q != '0 || pfree_q)) |-> ok_q)
		else $error("grant or free flag on a failed result");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.rd_en && mem_req.wr_en) |-> mem_req.rd_addr != mem_req.wr_addr)
		else $error("read and write of the same bitmap word in one cycle");

endmodule
